// File: src/lda_gibbs_token_sampler_defines.svh
// Assertion macros for the token sampler checker
`ifndef LDA_GIBBS_TOKEN_SAMPLER_DEFINES_SVH
`define LDA_GIBBS_TOKEN_SAMPLER_DEFINES_SVH
// implication checked on every clock edge out of reset
`define LGS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lgs check failed");
// implication checked in the cycle after the antecedent
`define LGS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lgs check failed");
`endif

// File: src/lgs_pkg.sv
// ---------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants for the LDA token sampler.
// ---------------------------------------------------------------------------
`default_nettype none
package lgs_pkg;
    localparam int MAX_TOPICS = 16;
    localparam int VOCAB_SIZE = 1024;
    localparam int NUM_DOCS   = 256;
    localparam int MAX_TOKENS = 16384;
    localparam int TW  = $clog2(MAX_TOPICS);
    localparam int WW  = $clog2(VOCAB_SIZE);
    localparam int DW  = $clog2(NUM_DOCS);
    localparam int XW  = $clog2(MAX_TOKENS);
    localparam int CW  = 15;
    localparam int KW  = 5;
    localparam int WTW = 64;
    localparam logic [CW-1:0] COUNT_MAX = 15'h7FFF;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_RESAMPLE = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [1:0] REG_ALPHA = 2'd0;
    localparam logic [1:0] REG_BETA = 2'd1;
    localparam logic [1:0] REG_TOPICS = 2'd2;

    typedef struct packed {
        logic          start;
        logic [WTW-1:0] num;
        logic [WTW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [WTW-1:0] quo;
    } div_rsp_t;
endpackage
`default_nettype wire

// File: src/lgs_divider.sv
// ---------------------------------------------------------------------------
// lgs_divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module lgs_divider
    import lgs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);
    logic [WTW-1:0] quo_reg, quo_next, den_reg, den_next;
    logic [WTW:0]   rem_reg, rem_next, trial;
    logic [6:0]     cnt_reg, cnt_next;
    logic           busy_reg, busy_next, done_reg, done_next;

    always_comb
    begin
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[WTW-1:0], quo_reg[WTW-1]};
        if (req.start)
        begin
            quo_next  = req.num;
            den_next  = req.den;
            rem_next  = '0;
            cnt_next  = 7'(WTW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[WTW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[WTW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
endmodule
`default_nettype wire

// File: src/lda_gibbs_token_sampler.sv
// ---------------------------------------------------------------------------
// lda_gibbs_token_sampler
// Collapsed Gibbs topic sampler with count memories and shared divider.
// ---------------------------------------------------------------------------
// Usage: input beats on s_axis (tdata: op, token_index, doc_id, word_id,
// topic_in, rand_fraction), one result beat per input on m_axis (token_out,
// topic_out, count_out). Config writes on cfg_valid/cfg_ready/cfg_index/
// cfg_data while idle. After reset a clearing pass zeroes the count memories;
// s_axis_tready stays low during it. A resample runs token lookup, count
// decrement, then per topic a count read, a 32x32 multiply and a division on
// the one-bit-per-cycle divider; then the target from two 32x32 partial
// products, a walk over the topics and the count increment. A load runs only
// the count increment, a read only the count read, and an unknown op goes
// straight to the output state.
// One item at a time; s_axis_tready is low from acceptance until the result
// is loaded into the output register, and the next beat can be accepted in the
// same cycle that the result appears. A stalled receiver holds the result in the
// output register; a finished next item waits until that beat is taken.
// ---------------------------------------------------------------------------
`default_nettype none
module lda_gibbs_token_sampler
    import lgs_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // op[1:0], token_index[15:2], doc_id[23:16], word_id[33:24],
    // topic_in[37:34], rand_fraction[69:38], zero fill
    input  wire logic [71:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // token_out[13:0], topic_out[17:14], count_out[32:18], zero fill
    output logic [39:0]       m_axis_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);
    typedef enum logic [11:0] {
        S_CLEAR  = 12'b000000000001,
        S_IDLE   = 12'b000000000010,
        S_TOK    = 12'b000000000100,
        S_DEC    = 12'b000000001000,
        S_RD     = 12'b000000010000,
        S_MUL    = 12'b000000100000,
        S_DIV    = 12'b000001000000,
        S_TGT    = 12'b000010000000,
        S_WALK   = 12'b000100000000,
        S_INC    = 12'b001000000000,
        S_READ   = 12'b010000000000,
        S_OUT    = 12'b100000000000
    } state_t;

    localparam int WTA = WW + TW;
    localparam int DTA = DW + TW;

    state_t state_reg, state_next;

    // memories
    logic [TW-1:0] tok_topic_mem [MAX_TOKENS];
    logic [WW-1:0] tok_word_mem  [MAX_TOKENS];
    logic [DW-1:0] tok_doc_mem   [MAX_TOKENS];
    logic [CW-1:0] wt_mem [VOCAB_SIZE*MAX_TOPICS];
    logic [CW-1:0] dt_mem [NUM_DOCS*MAX_TOPICS];
    logic [CW-1:0] tot_reg [MAX_TOPICS];
    logic [WTW-1:0] wgt_reg [MAX_TOPICS];

    logic [15:0] alpha_reg, beta_reg;
    logic [KW-1:0] kin_reg;
    logic [KW-1:0] kact;

    logic [XW-1:0] tok_reg;
    logic [DW-1:0] doc_reg;
    logic [WW-1:0] word_reg;
    logic [TW-1:0] tin_reg, topic_reg;
    logic [31:0] rnd_reg;
    logic [2:0]  sub_reg;
    logic [KW-1:0] k_reg;
    logic [WTA:0] clr_reg;
    logic [CW-1:0] wt_q, dt_q, cnt_reg;
    logic [TW-1:0] tt_q;
    logic [WW-1:0] tw_q;
    logic [DW-1:0] td_q;
    logic [31:0] a_reg, b_reg;
    logic [63:0] prod_reg, sum_reg, run_reg, tgt_reg;
    logic [WTW-1:0] den_reg;
    logic found_reg;
    logic [39:0] out_reg;
    logic ovalid_reg;

    // memory ports
    logic wt_we, dt_we, tok_we;
    logic [WTA-1:0] wt_addr;
    logic [DTA-1:0] dt_addr;
    logic [CW-1:0] wt_wd, dt_wd;

    div_req_t dreq;
    div_rsp_t drsp;

    lgs_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign kact = (kin_reg == '0) ? KW'(1) :
                  (kin_reg > KW'(MAX_TOPICS)) ? KW'(MAX_TOPICS) : kin_reg;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = out_reg;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
        return (c < COUNT_MAX) ? c + CW'(1) : c;
    endfunction
    function automatic logic [CW-1:0] sat_dec(input logic [CW-1:0] c);
        return (c != '0) ? c - CW'(1) : c;
    endfunction

    logic [TW-1:0] cur_t;
    logic [63:0] pp;
    logic [63:0] nd_s, nw_s;

    always_comb
    begin
        cur_t   = (state_reg == S_INC) ? topic_reg : k_reg[TW-1:0];
        if (state_reg == S_DEC) cur_t = topic_reg;
        wt_addr = (state_reg == S_CLEAR) ? clr_reg[WTA-1:0]
                : (state_reg == S_READ) ? {word_reg, tin_reg} : {word_reg, cur_t};
        dt_addr = (state_reg == S_CLEAR) ? clr_reg[DTA-1:0] : {doc_reg, cur_t};
        wt_we = 1'b0;
        dt_we = 1'b0;
        tok_we = 1'b0;
        wt_wd = '0;
        dt_wd = '0;
        if (state_reg == S_CLEAR)
        begin
            wt_we = 1'b1;
            dt_we = (clr_reg[WTA-1:DTA] == '0);
        end
        else if ((state_reg == S_DEC || state_reg == S_INC) && sub_reg == 3'd2)
        begin
            wt_we = 1'b1;
            dt_we = 1'b1;
            wt_wd = (state_reg == S_INC) ? sat_inc(wt_q) : sat_dec(wt_q);
            dt_wd = (state_reg == S_INC) ? sat_inc(dt_q) : sat_dec(dt_q);
            tok_we = (state_reg == S_INC);
        end
        pp = {32'd0, a_reg} * {32'd0, b_reg};
        nd_s = {37'd0, dt_q, 12'd0} + {48'd0, alpha_reg};
        nw_s = {37'd0, wt_q, 12'd0} + {48'd0, beta_reg};
        dreq.start = 1'b0;
        dreq.num = prod_reg;
        dreq.den = den_reg;
        if (state_reg == S_MUL && sub_reg == 3'd1)
            dreq.start = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wt_we) wt_mem[wt_addr] <= wt_wd;
        wt_q <= wt_mem[wt_addr];
        if (dt_we) dt_mem[dt_addr] <= dt_wd;
        dt_q <= dt_mem[dt_addr];
        if (tok_we)
        begin
            tok_topic_mem[tok_reg] <= topic_reg;
            tok_word_mem[tok_reg]  <= word_reg;
            tok_doc_mem[tok_reg]   <= doc_reg;
        end
        tt_q <= tok_topic_mem[tok_reg];
        tw_q <= tok_word_mem[tok_reg];
        td_q <= tok_doc_mem[tok_reg];
    end

    logic [63:0] den_calc;
    always_comb
    begin
        den_calc = {37'd0, tot_reg[k_reg[TW-1:0]], 12'd0}
                 + 64'({48'd0, beta_reg} * {59'd0, kact});
        if (den_calc == '0) den_calc = 64'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
            alpha_reg  <= 16'd410;
            beta_reg   <= 16'd41;
            kin_reg    <= 5'd16;
            sub_reg    <= '0;
            k_reg      <= '0;
            for (int i = 0; i < MAX_TOPICS; i++) tot_reg[i] <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_ALPHA:  alpha_reg <= cfg_data;
                    REG_BETA:   beta_reg <= cfg_data;
                    REG_TOPICS: kin_reg <= cfg_data[KW-1:0];
                    default: ;
                endcase
            end
            if (ovalid_reg && m_axis_tready && state_reg != S_OUT) ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (WTA+1)'(VOCAB_SIZE*MAX_TOPICS - 1)) state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        tok_reg  <= s_axis_tdata[15:2];
                        doc_reg  <= s_axis_tdata[23:16];
                        word_reg <= s_axis_tdata[33:24];
                        tin_reg  <= s_axis_tdata[37:34];
                        rnd_reg  <= s_axis_tdata[69:38];
                        sub_reg  <= '0;
                        k_reg    <= '0;
                        unique case (s_axis_tdata[1:0])
                            OP_LOAD:
                            begin
                                topic_reg <= ({1'b0, s_axis_tdata[37:34]} >= kact)
                                           ? TW'(kact - 1'b1) : s_axis_tdata[37:34];
                                state_reg <= S_INC;
                            end
                            OP_RESAMPLE: state_reg <= S_TOK;
                            OP_READ: state_reg <= S_READ;
                            default:
                            begin
                                topic_reg <= '0;
                                cnt_reg   <= '0;
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_TOK:
                begin
                    if (sub_reg == 3'd1)
                    begin
                        word_reg  <= tw_q;
                        doc_reg   <= td_q;
                        topic_reg <= tt_q;
                        sub_reg   <= '0;
                        state_reg <= S_DEC;
                    end
                    else
                        sub_reg <= sub_reg + 3'd1;
                end
                S_DEC:
                begin
                    if (sub_reg == 3'd2)
                    begin
                        tot_reg[topic_reg] <= sat_dec(tot_reg[topic_reg]);
                        sub_reg   <= '0;
                        sum_reg   <= '0;
                        state_reg <= S_RD;
                    end
                    else
                        sub_reg <= sub_reg + 3'd1;
                end
                S_RD:
                begin
                    if (sub_reg == 3'd1)
                    begin
                        a_reg     <= nd_s[31:0];
                        b_reg     <= nw_s[31:0];
                        den_reg   <= den_calc;
                        sub_reg   <= '0;
                        state_reg <= S_MUL;
                    end
                    else
                        sub_reg <= sub_reg + 3'd1;
                end
                S_MUL:
                begin
                    if (sub_reg == 3'd0) prod_reg <= pp;
                    if (sub_reg == 3'd1)
                    begin
                        sub_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                    else
                        sub_reg <= sub_reg + 3'd1;
                end
                S_DIV:
                begin
                    if (drsp.done)
                    begin
                        wgt_reg[k_reg[TW-1:0]] <= drsp.quo;
                        sum_reg <= sum_reg + drsp.quo;
                        if (k_reg == kact - 1'b1)
                        begin
                            k_reg     <= '0;
                            sub_reg   <= '0;
                            tgt_reg   <= '0;
                            state_reg <= S_TGT;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_RD;
                        end
                    end
                end
                S_TGT:
                begin
                    // target = hi*r + (lo*r >> 32)
                    sub_reg <= sub_reg + 3'd1;
                    unique case (sub_reg)
                        3'd0:
                        begin
                            a_reg <= sum_reg[31:0];
                            b_reg <= rnd_reg;
                        end
                        3'd1: prod_reg <= pp;
                        3'd2:
                        begin
                            tgt_reg <= {32'd0, prod_reg[63:32]};
                            a_reg   <= sum_reg[63:32];
                        end
                        3'd3: prod_reg <= pp;
                        default:
                        begin
                            tgt_reg   <= tgt_reg + prod_reg;
                            run_reg   <= '0;
                            found_reg <= 1'b0;
                            topic_reg <= '0;
                            k_reg     <= '0;
                            state_reg <= S_WALK;
                        end
                    endcase
                end
                S_WALK:
                begin
                    if (!found_reg && sum_reg != '0
                        && run_reg + wgt_reg[k_reg[TW-1:0]] > tgt_reg)
                    begin
                        found_reg <= 1'b1;
                        topic_reg <= k_reg[TW-1:0];
                    end
                    run_reg <= run_reg + wgt_reg[k_reg[TW-1:0]];
                    k_reg   <= k_reg + 1'b1;
                    if (k_reg == kact - 1'b1)
                    begin
                        sub_reg   <= '0;
                        state_reg <= S_INC;
                    end
                end
                S_INC:
                begin
                    sub_reg <= sub_reg + 3'd1;
                    if (sub_reg == 3'd2)
                    begin
                        tot_reg[topic_reg] <= sat_inc(tot_reg[topic_reg]);
                        cnt_reg   <= '0;
                        state_reg <= S_OUT;
                    end
                end
                S_READ:
                begin
                    sub_reg <= sub_reg + 3'd1;
                    topic_reg <= tin_reg;
                    if (sub_reg == 3'd1)
                    begin
                        cnt_reg   <= wt_q;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!ovalid_reg || m_axis_tready)
                    begin
                        out_reg    <= {7'd0, cnt_reg, topic_reg, tok_reg};
                        ovalid_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: src/lgs_checker.sv
// ---------------------------------------------------------------------------
// lgs_checker
// Port-level checks for the token sampler, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "lda_gibbs_token_sampler_defines.svh"
module lgs_checker
    import lgs_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);
    `LGS_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `LGS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    `LGS_ASSERT_IMP(a_pad_zero, m_axis_tvalid, m_axis_tdata[39:33] == 7'd0)
    `LGS_ASSERT_NEXT(a_valid_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule

bind lda_gibbs_token_sampler lgs_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for lda_gibbs_token_sampler. A directed table covers
// reset state, field extremes, clamped topics, zero priors and all ops; then
// random phases under several prior and topic settings run loads, resamples
// and reads against an in-bench count model, with random gaps and stalls.
// ---------------------------------------------------------------------------
`default_nettype none
module tb;
    import lgs_pkg::*;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  reg_idx;
        logic [15:0] reg_val;
        logic [1:0]  op;
        logic [13:0] tok;
        logic [7:0]  doc;
        logic [9:0]  word;
        logic [3:0]  tin;
        logic [31:0] rnd;
        bit          fixed;
        logic [3:0]  want_topic;
        logic [14:0] want_count;
    } stim_row_t;

    typedef struct {
        logic [13:0] tok;
        logic [3:0]  topic;
        logic [14:0] count;
    } token_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata;  // op, token_index, doc_id, word_id, topic_in, rand_fraction
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [39:0]  m_axis_tdata;  // token_out, topic_out, count_out
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [15:0]  cfg_data;

    lda_gibbs_token_sampler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // count model
    logic [CW-1:0] wt_count  [0:VOCAB_SIZE*MAX_TOPICS-1];
    logic [CW-1:0] dt_count  [0:NUM_DOCS*MAX_TOPICS-1];
    logic [CW-1:0] tot_count [0:MAX_TOPICS-1];
    logic [TW-1:0] tk_topic  [0:MAX_TOKENS-1];
    logic [WW-1:0] tk_word   [0:MAX_TOKENS-1];
    logic [DW-1:0] tk_doc    [0:MAX_TOKENS-1];
    bit            tk_loaded [0:MAX_TOKENS-1];
    logic [13:0]   loaded_list[$];
    logic [15:0]   alpha_cfg;
    logic [15:0]   beta_cfg;
    logic [4:0]    topics_cfg;

    token_result_t pending_results[$];
    stim_row_t     dir_rows[$];
    int            errors;
    int            results_seen;
    int            n_load, n_resample, n_read, n_other, n_cfg;
    bit            no_gaps;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("timeout at %0t", $time);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int active_k();
        if (topics_cfg == 0) return 1;
        if (topics_cfg > MAX_TOPICS) return MAX_TOPICS;
        return topics_cfg;
    endfunction

    task automatic bump(input logic [9:0] w, input logic [7:0] d, input logic [3:0] t,
                        input bit up);
        int wi;
        int di;
        wi = w * MAX_TOPICS + t;
        di = d * MAX_TOPICS + t;
        if (up)
        begin
            if (wt_count[wi] != COUNT_MAX) wt_count[wi]++;
            if (dt_count[di] != COUNT_MAX) dt_count[di]++;
            if (tot_count[t] != COUNT_MAX) tot_count[t]++;
        end
        else
        begin
            if (wt_count[wi] != 0) wt_count[wi]--;
            if (dt_count[di] != 0) dt_count[di]--;
            if (tot_count[t] != 0) tot_count[t]--;
        end
    endtask

    // advances the count model by one token op and returns its result
    task automatic gibbs_update(input stim_row_t r, output token_result_t res);
        int          k;
        int          kact;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] den;
        logic [63:0] wt [0:MAX_TOPICS-1];
        logic [63:0] sum;
        logic [63:0] run;
        logic [95:0] target;
        logic [9:0]  w;
        logic [7:0]  d;
        bit          found;
        kact = active_k();
        res.tok = r.tok;
        res.topic = 0;
        res.count = 0;
        if (r.op == OP_LOAD)
        begin
            res.topic = (r.tin >= kact) ? 4'(kact - 1) : r.tin;
            tk_topic[r.tok] = res.topic;
            tk_word[r.tok] = r.word;
            tk_doc[r.tok] = r.doc;
            if (!tk_loaded[r.tok]) loaded_list.insert(loaded_list.size(), r.tok);
            tk_loaded[r.tok] = 1'b1;
            bump(r.word, r.doc, res.topic, 1'b1);
        end
        else if (r.op == OP_RESAMPLE)
        begin
            w = tk_word[r.tok];
            d = tk_doc[r.tok];
            bump(w, d, tk_topic[r.tok], 1'b0);
            sum = 0;
            for (k = 0; k < kact; k++)
            begin
                a = {37'd0, dt_count[d * MAX_TOPICS + k], 12'd0} + alpha_cfg;
                b = {37'd0, wt_count[w * MAX_TOPICS + k], 12'd0} + beta_cfg;
                den = {37'd0, tot_count[k], 12'd0} + 64'(kact) * beta_cfg;
                if (den == 0) den = 1;
                wt[k] = (a * b) / den;
                sum += wt[k];
            end
            target = ({32'd0, sum} * {64'd0, r.rnd}) >> 32;
            run = 0;
            found = 0;
            if (sum != 0)
            begin
                for (k = 0; k < kact; k++)
                begin
                    run += wt[k];
                    if (!found && {32'd0, run} > target)
                    begin
                        res.topic = 4'(k);
                        found = 1;
                    end
                end
            end
            tk_topic[r.tok] = res.topic;
            bump(w, d, res.topic, 1'b1);
        end
        else if (r.op == OP_READ)
        begin
            res.topic = r.tin;
            res.count = wt_count[r.word * MAX_TOPICS + r.tin];
        end
    endtask

    function automatic stim_row_t item_row(input logic [1:0] op, input logic [13:0] tok,
                                           input logic [7:0] doc, input logic [9:0] word,
                                           input logic [3:0] tin, input logic [31:0] rnd,
                                           input bit fixed, input logic [3:0] topic,
                                           input logic [14:0] count);
        stim_row_t r;
        r = '{default: '0};
        r.op = op;
        r.tok = tok;
        r.doc = doc;
        r.word = word;
        r.tin = tin;
        r.rnd = rnd;
        r.fixed = fixed;
        r.want_topic = topic;
        r.want_count = count;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [1:0] idx, input logic [15:0] val);
        stim_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    task automatic add_row(input stim_row_t r);
        dir_rows.insert(dir_rows.size(), r);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ALPHA:  alpha_cfg = val;
            REG_BETA:   beta_cfg = val;
            REG_TOPICS: topics_cfg = val[4:0];
            default: ;
        endcase
        n_cfg++;
        @(posedge clk);
    endtask

    task automatic send_item(input stim_row_t r);
        token_result_t res;
        int gap;
        gap = 0;
        if (!no_gaps)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4: gap = $urandom_range(1, 3);
                5:             gap = $urandom_range(20, 120);
                default:       gap = 0;
            endcase
        end
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, r.rnd, r.tin, r.word, r.doc, r.tok, r.op};
        do @(posedge clk); while (!s_axis_tready);
        gibbs_update(r, res);
        if (r.fixed)
        begin
            res.topic = r.want_topic;
            res.count = r.want_count;
        end
        pending_results.insert(pending_results.size(), res);
        case (r.op)
            OP_LOAD:     n_load++;
            OP_RESAMPLE: n_resample++;
            OP_READ:     n_read++;
            default:     n_other++;
        endcase
    endtask

    function automatic logic [31:0] pick_fraction();
        case ($urandom_range(0, 19))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic stim_row_t random_item();
        stim_row_t r;
        int        sel;
        bit        wide;
        r = '{default: '0};
        sel = $urandom_range(0, 99);
        wide = ($urandom_range(0, 4) == 0);
        r.rnd = pick_fraction();
        r.tin = 4'($urandom_range(0, 15));
        r.doc = wide ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 15));
        r.word = wide ? 10'($urandom_range(0, 1023)) : 10'($urandom_range(0, 31));
        r.tok = wide ? 14'($urandom_range(0, 16383)) : 14'($urandom_range(0, 127));
        if (sel < 45 && loaded_list.size() != 0)
        begin
            r.op = OP_RESAMPLE;
            r.tok = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
        end
        else if (sel < 60)
            r.op = OP_READ;
        else if (sel < 64)
            r.op = 2'd3;
        else
            r.op = OP_LOAD;
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        token_result_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat %h", $time, m_axis_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[13:0] != want.tok)
                begin
                    errors++;
                    $display("%0t: token_out exp %0d got %0d", $time, want.tok,
                             m_axis_tdata[13:0]);
                end
                if (m_axis_tdata[17:14] != want.topic)
                begin
                    errors++;
                    $display("%0t: topic_out exp %0d got %0d (token %0d)", $time,
                             want.topic, m_axis_tdata[17:14], want.tok);
                end
                if (m_axis_tdata[32:18] != want.count)
                begin
                    errors++;
                    $display("%0t: count_out exp %0d got %0d (token %0d)", $time,
                             want.count, m_axis_tdata[32:18], want.tok);
                end
            end
        end
    end

    // result sink: random stalls, free-running stretches, one long hold
    int  sink_stall = 0;
    int  sink_cycle = 0;
    bit  long_hold_done = 0;
    always @(posedge clk)
    begin
        sink_cycle++;
        if (!long_hold_done && n_load + n_resample + n_read > 300)
        begin
            long_hold_done = 1;
            sink_stall = 4000;
        end
        if (sink_stall > 0)
        begin
            sink_stall--;
            m_axis_tready <= 1'b0;
        end
        else if ((sink_cycle / 30000) % 4 == 1)
            m_axis_tready <= 1'b1;
        else
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3: sink_stall = $urandom_range(1, 4);
                5:          sink_stall = $urandom_range(20, 150);
                default:    ;
            endcase
            m_axis_tready <= (sink_stall == 0);
        end
    end

    logic [15:0] ph_alpha [0:5] = '{16'd410, 16'd1, 16'd65535, 16'd4096, 16'd200, 16'd0};
    logic [15:0] ph_beta  [0:5] = '{16'd41, 16'd1, 16'd65535, 16'd4096, 16'd800, 16'd0};
    logic [4:0]  ph_k     [0:5] = '{5'd16, 5'd1, 5'd16, 5'd31, 5'd0, 5'd0};

    initial
    begin
        stim_row_t r;
        int        i;
        int        p;
        errors = 0;
        results_seen = 0;
        n_load = 0;
        n_resample = 0;
        n_read = 0;
        n_other = 0;
        n_cfg = 0;
        no_gaps = 0;
        alpha_cfg = 16'd410;
        beta_cfg = 16'd41;
        topics_cfg = 5'd16;
        for (i = 0; i < VOCAB_SIZE * MAX_TOPICS; i++) wt_count[i] = '0;
        for (i = 0; i < NUM_DOCS * MAX_TOPICS; i++) dt_count[i] = '0;
        for (i = 0; i < MAX_TOPICS; i++) tot_count[i] = '0;
        for (i = 0; i < MAX_TOKENS; i++) tk_loaded[i] = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        add_row(item_row(OP_READ, 14'd0, 8'd0, 10'd0, 4'd0, 32'd0, 1, 4'd0, 15'd0));
        add_row(item_row(OP_READ, 14'd9, 8'd0, 10'd1023, 4'd15, 32'd0, 1, 4'd15,
                         15'd0));
        add_row(item_row(2'd3, 14'd16383, 8'd255, 10'd1023, 4'd15, 32'hFFFF_FFFF, 1,
                         4'd0, 15'd0));
        add_row(item_row(OP_LOAD, 14'd0, 8'd0, 10'd0, 4'd0, 32'd0, 1, 4'd0, 15'd0));
        add_row(item_row(OP_LOAD, 14'd16383, 8'd255, 10'd1023, 4'd15, 32'hFFFF_FFFF,
                         1, 4'd15, 15'd0));
        add_row(item_row(OP_LOAD, 14'd1, 8'd0, 10'd0, 4'd3, 32'd0, 1, 4'd3, 15'd0));
        add_row(item_row(OP_LOAD, 14'd0, 8'd0, 10'd0, 4'd0, 32'd0, 1, 4'd0, 15'd0));
        add_row(item_row(OP_READ, 14'd0, 8'd0, 10'd0, 4'd0, 32'd0, 1, 4'd0, 15'd2));
        add_row(item_row(OP_RESAMPLE, 14'd0, 8'd0, 10'd0, 4'd0, 32'd0, 0, 0, 0));
        add_row(item_row(OP_RESAMPLE, 14'd16383, 8'd0, 10'd0, 4'd0, 32'hFFFF_FFFF,
                         0, 0, 0));
        add_row(item_row(OP_RESAMPLE, 14'd1, 8'd0, 10'd0, 4'd0, 32'h8000_0000, 0, 0,
                         0));
        add_row(item_row(OP_READ, 14'd5, 8'd0, 10'd1023, 4'd15, 32'd0, 0, 0, 0));
        add_row(cfg_row(REG_TOPICS, 16'd4));
        add_row(item_row(OP_LOAD, 14'd2, 8'd1, 10'd5, 4'd15, 32'd0, 1, 4'd3, 15'd0));
        add_row(item_row(OP_RESAMPLE, 14'd2, 8'd0, 10'd0, 4'd0, 32'hFFFF_FFFF, 0, 0,
                         0));
        // zero priors: empty document gives all-zero weights, empty topics zero denominators
        add_row(cfg_row(REG_ALPHA, 16'd0));
        add_row(cfg_row(REG_BETA, 16'd0));
        add_row(item_row(OP_LOAD, 14'd3, 8'd200, 10'd900, 4'd0, 32'd0, 1, 4'd0,
                         15'd0));
        add_row(item_row(OP_RESAMPLE, 14'd3, 8'd0, 10'd0, 4'd0, 32'h1234_5678, 1,
                         4'd0, 15'd0));
        add_row(cfg_row(REG_TOPICS, 16'd0));
        add_row(item_row(OP_LOAD, 14'd4, 8'd3, 10'd3, 4'd9, 32'd0, 1, 4'd0, 15'd0));
        add_row(item_row(OP_RESAMPLE, 14'd4, 8'd0, 10'd0, 4'd0, 32'hFFFF_FFFF, 0, 0,
                         0));
        add_row(cfg_row(REG_TOPICS, 16'd31));
        add_row(cfg_row(REG_ALPHA, 16'hFFFF));
        add_row(cfg_row(REG_BETA, 16'hFFFF));
        add_row(item_row(OP_LOAD, 14'd5, 8'd255, 10'd1023, 4'd15, 32'd0, 1, 4'd15,
                         15'd0));
        add_row(item_row(OP_RESAMPLE, 14'd5, 8'd0, 10'd0, 4'd0, 32'hFFFF_FFFF, 0, 0,
                         0));

        foreach (dir_rows[j])
        begin
            if (dir_rows[j].is_cfg)
                write_reg(dir_rows[j].reg_idx, dir_rows[j].reg_val);
            else
                send_item(dir_rows[j]);
        end

        for (p = 0; p < 6; p++)
        begin
            if (p == 5)
            begin
                ph_alpha[5] = 16'($urandom_range(1, 65535));
                ph_beta[5] = 16'($urandom_range(1, 65535));
                ph_k[5] = 5'($urandom_range(2, 8));
            end
            write_reg(REG_ALPHA, ph_alpha[p]);
            write_reg(REG_BETA, ph_beta[p]);
            write_reg(REG_TOPICS, {11'd0, ph_k[p]});
            no_gaps = (p % 2 == 1);
            for (i = 0; i < 315; i++)
            begin
                r = random_item();
                send_item(r);
                if ($urandom_range(0, 99) == 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    while (pending_results.size() != 0) @(posedge clk);
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        $display("covered %0d loads, %0d resamples, %0d reads, %0d unknown ops, %0d reg writes",
                 n_load, n_resample, n_read, n_other, n_cfg);
        $display("%0d result beats checked, %0d mismatches", results_seen, errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
